### hdl/cupp_pkg.sv
package cupp_pkg;

  // Field widths fixed by the payload format.
  localparam int BYTE_W   = 8;
  localparam int SUB_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 15;
  localparam int CS_W     = 16;

  // Header layout and limits.
  localparam int HDR_KEEP = 16;
  localparam logic [COUNT_W-1:0] HDR_LAST  = 15'd17;
  localparam logic [COUNT_W-1:0] HDR_BYTES = 15'd18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;
  localparam logic [15:0]        MAGIC     = 16'h1111;
  localparam int MAX_SUBS_DEF = 512;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
  localparam logic [7:0]         FORMAT_INT16 = 8'd0;
  localparam logic [SUB_W-1:0]   CAPACITY_RST = 13'd512;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_FORMAT   = 3'd5,
    ST_CAPACITY = 3'd6
  } status_t;

  // One queue word: an optional subcarrier and an optional packet summary.
  typedef struct packed {
    logic                has_sub;
    logic [SUB_W-1:0]    sub_idx;
    logic [SAMPLE_W-1:0] i_raw;
    logic [SAMPLE_W-1:0] q_raw;
    logic                has_sum;
    status_t             status;
    logic [SUB_W-1:0]    nsub;
    logic [CS_W-1:0]     chanspec;
    logic [7:0]          rssi;
    logic [5:0]          core_ss;
    logic [15:0]         seq;
  } cupp_entry_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic                is_summary;
    logic [SUB_W-1:0]    sub_index;
    logic [SAMPLE_W-1:0] i_value;
    logic [SAMPLE_W-1:0] q_value;
    logic [2:0]          status;
    logic [7:0]          channel;
    logic [7:0]          bw_mhz;
    logic                is_5ghz;
    logic [7:0]          rssi_val;
    logic [2:0]          core_number;
    logic [2:0]          stream_num;
    logic [15:0]         seq_count;
  } cupp_result_t;

endpackage

### hdl/csi_udp_payload_parser.sv
// CSI UDP payload parser. Takes one payload byte per clock with a last-byte marker,
// checks the 18-byte header and emits one word per completed subcarrier (raw int16
// I and Q) followed by a summary word at the end of every packet; subcarrier words
// of a packet whose summary status is nonzero are to be dropped by the consumer.
// Throughput is one byte per clock while in_stall is low. The front end classifies
// bytes and writes a four-word queue; the back end drains one word per clock into the
// output register while out_stall is low; a queue word with both parts gives its
// subcarrier first. Configuration is written through cfg_* (index 0 format, index 1
// capacity); the user must write it only while idle, as the block does not enforce it.
module csi_udp_payload_parser #(
  parameter int MAX_SUBS = cupp_pkg::MAX_SUBS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cupp_pkg::BYTE_W-1:0]         in_byte_value,
  input  logic                                in_is_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_summary,
  output logic [cupp_pkg::SUB_W-1:0]          out_sub_index,
  output logic signed [cupp_pkg::SAMPLE_W-1:0] out_i_value,
  output logic signed [cupp_pkg::SAMPLE_W-1:0] out_q_value,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_chan_num,
  output logic [7:0]                          out_bw_mhz,
  output logic                                out_band_5g,
  output logic signed [7:0]                   out_rssi_val,
  output logic [2:0]                          out_core_number,
  output logic [2:0]                          out_stream_num,
  output logic [15:0]                         out_seq_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cupp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cupp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cupp_pkg::*;

  cupp_entry_t  push_word;
  cupp_entry_t  head_word;
  cupp_result_t res;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;

  // Front end: byte counting, header capture and status.
  cupp_front #(
    .MAX_SUBS(MAX_SUBS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_is_last_byte (in_is_last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_word          (push_word)
  );

  // Queue between the two halves.
  cupp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head_word (head_word),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: result formatting and output register.
  cupp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_word (head_word),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (res)
  );

  // Result fields onto the ports.
  assign out_is_summary  = res.is_summary;
  assign out_sub_index   = res.sub_index;
  assign out_i_value     = res.i_value;
  assign out_q_value     = res.q_value;
  assign out_status      = res.status;
  assign out_chan_num    = res.channel;
  assign out_bw_mhz      = res.bw_mhz;
  assign out_band_5g     = res.is_5ghz;
  assign out_rssi_val    = res.rssi_val;
  assign out_core_number = res.core_number;
  assign out_stream_num  = res.stream_num;
  assign out_seq_count   = res.seq_count;

endmodule

### hdl/cupp_front.sv
module cupp_front #(
  parameter int MAX_SUBS = cupp_pkg::MAX_SUBS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cupp_pkg::BYTE_W-1:0]         in_byte_value,
  input  logic                                in_is_last_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cupp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cupp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output cupp_pkg::cupp_entry_t               q_word
);
  import cupp_pkg::*;

  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  hdr_r [HDR_KEEP];
  logic [BYTE_W-1:0]  smp_r [3];
  logic [7:0]         fmt_r;
  logic [SUB_W-1:0]   cap_r;

  logic               accept;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] csi;
  logic [SUB_W-1:0]   nsub;
  logic               in_body;
  logic               emit_sub;
  status_t            status;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FORMAT_INT16;
      cap_r <= CAPACITY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT:   fmt_r <= cfg_data[7:0];
        REG_CAPACITY: cap_r <= cfg_data[SUB_W-1:0];
        default:      ;
      endcase
    end
  end

  // Position of the byte inside the packet.
  assign pos      = cnt_r - HDR_BYTES;
  assign in_body  = (cnt_r >= HDR_BYTES) && (cnt_r < COUNT_MAX);
  assign emit_sub = in_body && (pos[1:0] == 2'd3);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_is_last_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r < COUNT_MAX) begin
        cnt_nxt = cnt_r + 15'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Header and sample byte stores; only the first 16 header bytes are kept.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r < COUNT_W'(HDR_KEEP)) begin
        hdr_r[cnt_r[$clog2(HDR_KEEP)-1:0]] <= in_byte_value;
      end
      if (in_body) begin
        case (pos[1:0])
          2'd0:    smp_r[0] <= in_byte_value;
          2'd1:    smp_r[1] <= in_byte_value;
          2'd2:    smp_r[2] <= in_byte_value;
          default: ;
        endcase
      end
    end
  end

  // Packet status, checked in priority order on the final byte.
  assign csi  = cnt_r - HDR_LAST;
  assign nsub = csi[COUNT_W-1:2];

  always_comb begin
    if (fmt_r != FORMAT_INT16) begin
      status = ST_FORMAT;
    end else if (cnt_r < HDR_LAST) begin
      status = ST_SHORT;
    end else if ({hdr_r[1], hdr_r[0]} != MAGIC) begin
      status = ST_MAGIC;
    end else if (cnt_r >= COUNT_MAX) begin
      status = ST_TOO_MANY;
    end else if ((csi == '0) || (csi[1:0] != 2'd0)) begin
      status = ST_LENGTH;
    end else if (nsub > SUB_W'(MAX_SUBS)) begin
      status = ST_TOO_MANY;
    end else if (nsub > cap_r) begin
      status = ST_CAPACITY;
    end else begin
      status = ST_OK;
    end
  end

  // Queue word for this byte.
  always_comb begin
    q_push           = accept && (emit_sub || in_is_last_byte);
    q_word.has_sub   = emit_sub;
    q_word.sub_idx   = pos[SUB_W+1:2];
    q_word.i_raw     = {smp_r[1], smp_r[0]};
    q_word.q_raw     = {in_byte_value, smp_r[2]};
    q_word.has_sum   = in_is_last_byte;
    q_word.status    = status;
    q_word.nsub      = (status == ST_OK) ? nsub : '0;
    q_word.chanspec  = {hdr_r[15], hdr_r[14]};
    q_word.rssi      = hdr_r[2];
    q_word.core_ss   = hdr_r[12][5:0];
    q_word.seq       = {hdr_r[11], hdr_r[10]};
  end

endmodule

### hdl/cupp_queue.sv
module cupp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cupp_pkg::cupp_entry_t push_word,
  input  logic                  pop,
  output cupp_pkg::cupp_entry_t head_word,
  output logic                  empty,
  output logic                  full
);
  import cupp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cupp_entry_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (fill_r == '0);
  assign head_word = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### hdl/cupp_back.sv
module cupp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cupp_pkg::cupp_entry_t  head_word,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cupp_pkg::cupp_result_t out_word
);
  import cupp_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         sub_done_r, sub_done_nxt;
  cupp_result_t res_r, res_nxt;
  cupp_result_t sub_res;
  cupp_result_t sum_res;
  logic         load;
  logic [7:0]   ch;
  logic [7:0]   bw_cs;
  logic [7:0]   bw_n;
  logic         g5;

  // Bandwidth from the chanspec bandwidth code.
  function automatic logic [7:0] bw_of_chanspec(input logic [2:0] code);
    case (code)
      3'd2:    bw_of_chanspec = 8'd20;
      3'd3:    bw_of_chanspec = 8'd40;
      3'd4:    bw_of_chanspec = 8'd80;
      3'd5:    bw_of_chanspec = 8'd160;
      3'd6:    bw_of_chanspec = 8'd80;
      default: bw_of_chanspec = 8'd0;
    endcase
  endfunction

  // Bandwidth implied by the FFT size.
  function automatic logic [7:0] bw_of_count(input logic [SUB_W-1:0] n);
    case (n)
      13'd16:  bw_of_count = 8'd5;
      13'd32:  bw_of_count = 8'd10;
      13'd64:  bw_of_count = 8'd20;
      13'd128: bw_of_count = 8'd40;
      13'd256: bw_of_count = 8'd80;
      13'd512: bw_of_count = 8'd160;
      default: bw_of_count = 8'd0;
    endcase
  endfunction

  // Subcarrier word.
  always_comb begin
    sub_res            = '0;
    sub_res.sub_index  = head_word.sub_idx;
    sub_res.i_value    = head_word.i_raw;
    sub_res.q_value    = head_word.q_raw;
  end

  // Summary word with the band decision.
  always_comb begin
    ch    = head_word.chanspec[7:0];
    bw_cs = bw_of_chanspec(head_word.chanspec[13:11]);
    bw_n  = bw_of_count(head_word.nsub);
    g5    = (head_word.chanspec[15:14] == 2'b11);
    if (!g5 && (ch > 8'd14)) begin
      g5 = 1'b1;
    end
    if (g5 && (ch >= 8'd1) && (ch <= 8'd13) && (bw_cs == 8'd20)) begin
      g5 = 1'b0;
    end
    sum_res            = '0;
    sum_res.is_summary = 1'b1;
    sum_res.status     = head_word.status;
    if (head_word.status == ST_OK) begin
      sum_res.sub_index   = head_word.nsub;
      sum_res.channel     = ch;
      sum_res.bw_mhz      = (bw_n != 8'd0) ? bw_n : bw_cs;
      sum_res.is_5ghz     = g5;
      sum_res.rssi_val    = head_word.rssi;
      sum_res.core_number = head_word.core_ss[2:0];
      sum_res.stream_num  = head_word.core_ss[5:3];
      sum_res.seq_count   = head_word.seq;
    end
  end

  // Output register: a queue word with both parts gives its subcarrier first.
  always_comb begin
    load          = !out_valid_r || !out_stall;
    q_pop         = 1'b0;
    sub_done_nxt  = sub_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    if (load && !q_empty) begin
      out_valid_nxt = 1'b1;
      if (head_word.has_sub && !sub_done_r) begin
        res_nxt = sub_res;
        if (head_word.has_sum) begin
          sub_done_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        res_nxt      = sum_res;
        q_pop        = 1'b1;
        sub_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_done_r  <= sub_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

endmodule
